>>> rtl/ifd_pkg.sv
// Shared types, field codes and helpers of the instruction field decoder.
// Used by ifd_field_unit, instruction_field_decoder and ifd_checker.
// No dependencies.
package ifd_pkg;

    // Full width of the instruction byte window carried on the input
    localparam int WINDOW_BYTES        = 6;
    localparam int DEF_MAX_INSTR_BYTES = 6;

    // Commands (input tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_FIELD = 1'b1;

    // Field kinds
    localparam logic [4:0] KIND_NONE   = 5'd0;
    localparam logic [4:0] KIND_D      = 5'd1;
    localparam logic [4:0] KIND_S      = 5'd2;
    localparam logic [4:0] KIND_V      = 5'd3;
    localparam logic [4:0] KIND_W      = 5'd4;
    localparam logic [4:0] KIND_MOD    = 5'd5;
    localparam logic [4:0] KIND_RM     = 5'd6;
    localparam logic [4:0] KIND_REG    = 5'd7;
    localparam logic [4:0] KIND_SR     = 5'd8;
    localparam logic [4:0] KIND_INC8   = 5'd9;
    localparam logic [4:0] KIND_INCLO  = 5'd10;
    localparam logic [4:0] KIND_INCHI  = 5'd11;
    localparam logic [4:0] KIND_DISP   = 5'd12;
    localparam logic [4:0] KIND_DATA8  = 5'd13;
    localparam logic [4:0] KIND_DATALO = 5'd14;
    localparam logic [4:0] KIND_DATAHI = 5'd15;
    localparam logic [4:0] KIND_ADDRLO = 5'd16;
    localparam logic [4:0] KIND_ADDRHI = 5'd17;
    localparam logic [4:0] KIND_OPEXT  = 5'd18;

    // mod / rm encodings that select the displacement size
    localparam logic [1:0] MOD_NO_DISP = 2'b00;
    localparam logic [1:0] MOD_DISP8   = 2'b01;
    localparam logic [1:0] MOD_DISP16  = 2'b10;
    localparam logic [2:0] RM_DIRECT   = 3'b110;

    // Output tdata layout
    localparam int OUT_DATA_BITS = 24;
    localparam int OUT_CNT_LSB   = 16;
    localparam int OUT_WF_BIT    = 19;
    localparam int OUT_OVR_BIT   = 20;

    typedef struct packed {
        logic [47:0] instr_bytes;
        logic [4:0]  field_kind;
        logic        force_en;
        logic [7:0]  force_val;
        logic [2:0]  shift_amt;
        logic [7:0]  field_mask;
        logic [2:0]  byte_index;
    } item_t;

    typedef struct packed {
        logic [47:0] window;
        logic [2:0]  consumed;
        logic [1:0]  mode_bits;
        logic [2:0]  rm_bits;
        logic        width_bit;
        logic        sign_bit;
        logic [15:0] data_word;
        logic [15:0] ip_step;
        logic [15:0] address_word;
    } dec_state_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [15:0] field_value;
        logic [2:0]  bytes_consumed;
        logic        w_was_forced;
        logic        overrun;
    } result_t;

    // Byte i of the window; bytes past the six carried read as zero
    function automatic logic [7:0] win_byte(input logic [47:0] win, input logic [2:0] i);
        logic [63:0] ext;
        ext = {16'h0000, win};
        return ext[{i, 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/ifd_field_unit.sv
// Combinational decode of one field spec against the decoder state.
// Produces the next state and at most one result. Depends on ifd_pkg.
module ifd_field_unit import ifd_pkg::*;
#(
    parameter int MAX_INSTR_BYTES = DEF_MAX_INSTR_BYTES
)
(
    input  logic       command,
    input  item_t      item,
    input  dec_state_t state_cur,
    output dec_state_t state_next,
    output logic       has_result,
    output result_t    result
);

    localparam int         WinLen  = (MAX_INSTR_BYTES < WINDOW_BYTES) ?
                                     MAX_INSTR_BYTES : WINDOW_BYTES;
    localparam logic [2:0] WinLen3 = 3'(WinLen);

    // Sequential byte reads: first and second next byte
    logic       nb0_ovr, nb1_ovr, bf_ovr;
    logic [7:0] nb0, nb1, bf_byte, bf_val;
    logic [2:0] cnt1, cnt2, bf_cnt;

    always_comb
    begin
        nb0_ovr = state_cur.consumed >= WinLen3;
        nb0     = nb0_ovr ? 8'h00 : win_byte(state_cur.window, state_cur.consumed);
        cnt1    = nb0_ovr ? WinLen3 : state_cur.consumed + 3'd1;
        nb1_ovr = cnt1 >= WinLen3;
        nb1     = nb1_ovr ? 8'h00 : win_byte(state_cur.window, cnt1);
        cnt2    = nb1_ovr ? WinLen3 : cnt1 + 3'd1;

        // Bit fields mark every byte up to the indexed one as consumed
        bf_ovr  = item.byte_index >= WinLen3;
        bf_byte = bf_ovr ? 8'h00 : win_byte(state_cur.window, item.byte_index);
        if (bf_ovr)
            bf_cnt = WinLen3;
        else if (item.byte_index >= state_cur.consumed)
            bf_cnt = item.byte_index + 3'd1;
        else
            bf_cnt = state_cur.consumed;
        bf_val = item.force_en ? item.force_val
                               : ((bf_byte >> item.shift_amt) & item.field_mask);
    end

    always_comb
    begin
        state_next          = state_cur;
        has_result          = 1'b0;
        result.field_code   = item.field_kind;
        result.field_value  = 16'h0000;
        result.w_was_forced = 1'b0;
        result.overrun      = 1'b0;

        if (command == CMD_START) begin
            state_next.window   = item.instr_bytes;
            state_next.consumed = 3'd0;
        end else begin
            has_result = 1'b1;
            case (item.field_kind)
                KIND_D, KIND_S, KIND_V, KIND_W, KIND_MOD, KIND_RM, KIND_REG,
                KIND_SR, KIND_OPEXT:
                begin
                    state_next.consumed = bf_cnt;
                    result.overrun      = bf_ovr;
                    result.field_value  = {8'h00, bf_val};
                    if (item.field_kind == KIND_S)
                        state_next.sign_bit = bf_val[0];
                    if (item.field_kind == KIND_W) begin
                        state_next.width_bit = bf_val[0];
                        result.w_was_forced  = item.force_en;
                    end
                    if (item.field_kind == KIND_MOD)
                        state_next.mode_bits = bf_val[1:0];
                    if (item.field_kind == KIND_RM)
                        state_next.rm_bits = bf_val[2:0];
                end
                KIND_INC8, KIND_INCLO, KIND_INCHI:
                begin
                    state_next.consumed = cnt1;
                    result.overrun      = nb0_ovr;
                    if (item.field_kind == KIND_INC8)
                        state_next.ip_step = {{8{nb0[7]}}, nb0};
                    else if (item.field_kind == KIND_INCLO)
                        state_next.ip_step = {8'h00, nb0};
                    else
                        state_next.ip_step = {nb0, state_cur.ip_step[7:0]};
                    result.field_value = state_next.ip_step;
                end
                KIND_DISP:
                begin
                    if ((state_cur.mode_bits == MOD_NO_DISP && state_cur.rm_bits == RM_DIRECT)
                        || state_cur.mode_bits == MOD_DISP16) begin
                        state_next.consumed = cnt2;
                        result.overrun      = nb0_ovr | nb1_ovr;
                        result.field_value  = {nb1, nb0};
                    end else if (state_cur.mode_bits == MOD_DISP8) begin
                        state_next.consumed = cnt1;
                        result.overrun      = nb0_ovr;
                        result.field_value  = {{8{nb0[7]}}, nb0};
                    end
                end
                KIND_DATA8, KIND_DATALO:
                begin
                    state_next.consumed  = cnt1;
                    result.overrun       = nb0_ovr;
                    state_next.data_word = {8'h00, nb0};
                    result.field_value   = state_next.data_word;
                end
                KIND_DATAHI:
                begin
                    // High data byte only for word operands without sign extension
                    if (state_cur.width_bit && !state_cur.sign_bit) begin
                        state_next.consumed  = cnt1;
                        result.overrun       = nb0_ovr;
                        state_next.data_word = {nb0, state_cur.data_word[7:0]};
                    end
                    result.field_value = state_next.data_word;
                end
                KIND_ADDRLO, KIND_ADDRHI:
                begin
                    state_next.consumed = cnt1;
                    result.overrun      = nb0_ovr;
                    if (item.field_kind == KIND_ADDRLO)
                        state_next.address_word = {8'h00, nb0};
                    else
                        state_next.address_word = {nb0, state_cur.address_word[7:0]};
                    result.field_value = state_next.address_word;
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
        result.bytes_consumed = state_next.consumed;
    end

endmodule

>>> rtl/instruction_field_decoder.sv
// Top level of the instruction field decoder: input register, decode state,
// result register. Depends on ifd_pkg and ifd_field_unit.
//
//  channel  | direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+-----------
//  s_axis   | in        | instr bytes, kind, forced, fval, shift, | command
//           |           | mask, byte index (80 bits)             |
//  m_axis   | out       | value, consumed, w forced, overrun     | field code
//
// One item per cycle while the result register is not stalled: each item sits
// in the input register, where the decode unit reads and updates the state,
// then lands in the result register.
// Start commands and unknown kinds produce no result.
// A stalled result holds in the output register; the input register still
// takes an item and keeps it until the result register frees up.
// Reset clears all decode state, the window and both valid flags.
module instruction_field_decoder import ifd_pkg::*;
#(
    parameter int MAX_INSTR_BYTES = DEF_MAX_INSTR_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [47:0] instruction_bytes, [52:48] field_kind, [53] force_en,
    // [61:54] force_val, [64:62] shift_amt, [72:65] field_mask,
    // [75:73] byte_index, [79:76] zero
    input  logic [79:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] field_value, [18:16] bytes_consumed, [19] w_was_forced,
    // [20] overrun, [23:21] zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // [4:0] field_code
    output logic [4:0]  m_axis_tuser
);

    logic       in_valid_reg;
    logic       in_cmd_reg;
    item_t      in_item_reg;
    item_t      s_item;
    dec_state_t state_reg, state_next;
    logic       has_result;
    result_t    result;
    logic       advance;
    logic       out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [4:0] out_user_reg;

    always_comb
    begin
        s_item.instr_bytes = s_axis_tdata[47:0];
        s_item.field_kind  = s_axis_tdata[52:48];
        s_item.force_en    = s_axis_tdata[53];
        s_item.force_val   = s_axis_tdata[61:54];
        s_item.shift_amt   = s_axis_tdata[64:62];
        s_item.field_mask  = s_axis_tdata[72:65];
        s_item.byte_index  = s_axis_tdata[75:73];
    end

    ifd_field_unit #(
        .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
    ) u_field (
        .command    (in_cmd_reg),
        .item       (in_item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .has_result (has_result),
        .result     (result)
    );

    // Leave the input register when there is no result or the result has somewhere to go
    assign advance       = in_valid_reg && (!has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && has_result)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= s_item;
            in_cmd_reg  <= s_axis_tuser;
        end
        if (advance && has_result) begin
            out_user_reg <= result.field_code;
            out_data_reg <= {3'b000, result.overrun, result.w_was_forced,
                             result.bytes_consumed, result.field_value};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> rtl/ifd_checker.sv
// Port-level checks of the instruction field decoder, bound to the top level.
// Depends on ifd_pkg and instruction_field_decoder.
module ifd_checker import ifd_pkg::*;
#(
    parameter int MAX_INSTR_BYTES = DEF_MAX_INSTR_BYTES
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [4:0]               m_axis_tuser
);

    localparam int         WinLen  = (MAX_INSTR_BYTES < WINDOW_BYTES) ?
                                     MAX_INSTR_BYTES : WINDOW_BYTES;
    localparam logic [2:0] WinLen3 = 3'(WinLen);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != KIND_NONE && m_axis_tuser <= KIND_OPEXT)
        else $error("result for a kind that yields none");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_WF_BIT] |-> m_axis_tuser == KIND_W)
        else $error("w forced flag on a kind other than w");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_OVR_BIT] |->
            m_axis_tdata[OUT_CNT_LSB +: 3] == WinLen3)
        else $error("overrun without saturated byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_CNT_LSB +: 3] <= WinLen3)
        else $error("byte count beyond window");

endmodule

bind instruction_field_decoder ifd_checker #(
    .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
) u_ifd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> sim/testbench.sv
// Self-checking bench for instruction_field_decoder: streams start commands
// and field specs, predicts every decoded field and checks the result stream.
// Depends on ifd_pkg and the RTL of the decoder.
module testbench;
    import ifd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int TARGET_ITEMS = 700;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT    = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int WIN_LEN      = (DEF_MAX_INSTR_BYTES < WINDOW_BYTES) ?
                                  DEF_MAX_INSTR_BYTES : WINDOW_BYTES;

    // Kind codes past the defined set
    localparam logic [4:0] KIND_BAD_FIRST = 5'd19;
    localparam logic [4:0] KIND_BAD_LAST  = 5'd31;

    typedef struct {
        logic  cmd;
        item_t spec;
    } spec_beat_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [79:0]              s_axis_tdata = '0;
    logic                     s_axis_tuser = CMD_START;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [4:0]               m_axis_tuser;

    spec_beat_t  pending_specs[$];
    result_t     expected_fields[$];
    dec_state_t  decoder_state = '0;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    logic        pressure_done = 1'b0;
    logic        calm = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;

    instruction_field_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Field prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] read_next_byte(inout logic ovr);
        logic [7:0] b;
        b = 8'h00;
        if (decoder_state.consumed < WIN_LEN)
        begin
            b = decoder_state.window[8 * decoder_state.consumed +: 8];
            decoder_state.consumed = decoder_state.consumed + 3'd1;
        end
        else
        begin
            ovr = 1'b1;
            decoder_state.consumed = 3'(WIN_LEN);
        end
        return b;
    endfunction

    // Bit fields claim every byte up to the one they look at
    function automatic logic [7:0] read_byte_upto(input logic [2:0] idx, inout logic ovr);
        if (idx >= WIN_LEN)
        begin
            ovr = 1'b1;
            decoder_state.consumed = 3'(WIN_LEN);
            return 8'h00;
        end
        if (idx >= decoder_state.consumed)
            decoder_state.consumed = idx + 3'd1;
        return decoder_state.window[8 * idx +: 8];
    endfunction

    function automatic logic [15:0] read_next_word(inout logic ovr);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = read_next_byte(ovr);
        hi = read_next_byte(ovr);
        return {hi, lo};
    endfunction

    task automatic predict_field(input spec_beat_t beat);
        result_t     r;
        item_t       s;
        logic        ovr;
        logic        wf;
        logic [7:0]  b;
        logic [15:0] v;
        s = beat.spec;
        ovr = 1'b0;
        wf = 1'b0;
        v = 16'h0000;
        if (beat.cmd == CMD_START)
        begin
            decoder_state.window = s.instr_bytes;
            decoder_state.consumed = 3'd0;
            return;
        end
        if (s.field_kind == KIND_NONE || s.field_kind > KIND_OPEXT)
            return;
        if (s.field_kind <= KIND_SR || s.field_kind == KIND_OPEXT)
        begin
            b = read_byte_upto(s.byte_index, ovr);
            v = {8'h00, s.force_en ? s.force_val : ((b >> s.shift_amt) & s.field_mask)};
            case (s.field_kind)
                KIND_S:   decoder_state.sign_bit = v[0];
                KIND_W:
                begin
                    decoder_state.width_bit = v[0];
                    wf = s.force_en;
                end
                KIND_MOD: decoder_state.mode_bits = v[1:0];
                KIND_RM:  decoder_state.rm_bits = v[2:0];
                default:  ;
            endcase
        end
        else
        begin
            case (s.field_kind)
                KIND_INC8:
                begin
                    b = read_next_byte(ovr);
                    decoder_state.ip_step = {{8{b[7]}}, b};
                    v = decoder_state.ip_step;
                end
                KIND_INCLO:
                begin
                    decoder_state.ip_step = {8'h00, read_next_byte(ovr)};
                    v = decoder_state.ip_step;
                end
                KIND_INCHI:
                begin
                    b = read_next_byte(ovr);
                    decoder_state.ip_step = {b, decoder_state.ip_step[7:0]};
                    v = decoder_state.ip_step;
                end
                KIND_DISP:
                begin
                    if (decoder_state.mode_bits == MOD_NO_DISP)
                    begin
                        if (decoder_state.rm_bits == RM_DIRECT)
                            v = read_next_word(ovr);
                    end
                    else if (decoder_state.mode_bits == MOD_DISP8)
                    begin
                        b = read_next_byte(ovr);
                        v = {{8{b[7]}}, b};
                    end
                    else if (decoder_state.mode_bits == MOD_DISP16)
                        v = read_next_word(ovr);
                end
                KIND_DATA8, KIND_DATALO:
                begin
                    decoder_state.data_word = {8'h00, read_next_byte(ovr)};
                    v = decoder_state.data_word;
                end
                KIND_DATAHI:
                begin
                    // high data byte exists only for word data without sign extension
                    if (decoder_state.width_bit == 1'b1 && decoder_state.sign_bit == 1'b0)
                    begin
                        b = read_next_byte(ovr);
                        decoder_state.data_word = {b, decoder_state.data_word[7:0]};
                    end
                    v = decoder_state.data_word;
                end
                KIND_ADDRLO:
                begin
                    decoder_state.address_word = {8'h00, read_next_byte(ovr)};
                    v = decoder_state.address_word;
                end
                default:
                begin
                    b = read_next_byte(ovr);
                    decoder_state.address_word = {b, decoder_state.address_word[7:0]};
                    v = decoder_state.address_word;
                end
            endcase
        end
        r.field_code = s.field_kind;
        r.field_value = v;
        r.bytes_consumed = decoder_state.consumed;
        r.w_was_forced = wf;
        r.overrun = ovr;
        expected_fields.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic item_t random_spec(input logic [4:0] kind);
        item_t      s;
        logic [31:0] a;
        logic [31:0] c;
        a = $urandom;
        c = $urandom;
        s.instr_bytes = {a[15:0], c};
        s.field_kind = kind;
        s.force_en = ($urandom_range(0, 3) == 0);
        a = $urandom;
        s.force_val = a[7:0];
        s.shift_amt = 3'($urandom_range(0, 7));
        s.field_mask = a[15:8];
        s.byte_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
        return s;
    endfunction

    function automatic item_t bit_spec(input logic [4:0] kind, input logic [2:0] idx,
                                       input logic [2:0] shift, input logic [7:0] mask);
        item_t s;
        s = random_spec(kind);
        s.force_en = 1'b0;
        s.byte_index = idx;
        s.shift_amt = shift;
        s.field_mask = mask;
        return s;
    endfunction

    task automatic push_beat(input logic cmd, input item_t s);
        spec_beat_t beat;
        beat.cmd = cmd;
        beat.spec = s;
        pending_specs.push_back(beat);
    endtask

    task automatic push_start(input logic [47:0] bytes);
        item_t s;
        s = random_spec(KIND_NONE);
        s.instr_bytes = bytes;
        push_beat(CMD_START, s);
    endtask

    task automatic push_forced(input logic [4:0] kind, input logic [7:0] fval,
                               input logic [2:0] idx);
        item_t s;
        s = random_spec(kind);
        s.force_en = 1'b1;
        s.force_val = fval;
        s.byte_index = idx;
        push_beat(CMD_FIELD, s);
    endtask

    // Opcode byte, modrm byte, displacement, then up to three random trailing fields
    task automatic push_instruction();
        item_t s;
        int    n_tail;
        push_beat(CMD_START, random_spec(KIND_NONE));
        s = bit_spec(KIND_W, 3'd0, 3'd0, 8'h01);
        s.force_en = ($urandom_range(0, 4) == 0);
        push_beat(CMD_FIELD, s);
        if ($urandom_range(0, 1) == 0)
            push_beat(CMD_FIELD, bit_spec(KIND_S, 3'd0, 3'd1, 8'h01));
        else
            push_beat(CMD_FIELD, bit_spec(KIND_D, 3'd0, 3'd1, 8'h01));
        s = bit_spec(KIND_MOD, 3'd1, 3'd6, 8'h03);
        s.force_en = ($urandom_range(0, 7) == 0);
        push_beat(CMD_FIELD, s);
        push_beat(CMD_FIELD, bit_spec(($urandom_range(0, 1) == 0) ? KIND_REG : KIND_OPEXT,
                                      3'd1, 3'd3, 8'h07));
        push_beat(CMD_FIELD, bit_spec(KIND_RM, 3'd1, 3'd0, 8'h07));
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        n_tail = $urandom_range(0, 3);
        repeat (n_tail)
            push_beat(CMD_FIELD, random_spec(5'(KIND_INC8 + $urandom_range(0, 8))));
    endtask

    task automatic build_stimulus();
        item_t s;
        // decode before any start reads the cleared window
        push_beat(CMD_FIELD, bit_spec(KIND_D, 3'd0, 3'd0, 8'h01));

        // word data, direct address: w=1 s=0, mod 00 rm 110
        push_start(48'h80FF_1234_0681);
        push_beat(CMD_FIELD, bit_spec(KIND_W, 3'd0, 3'd0, 8'h01));
        push_beat(CMD_FIELD, bit_spec(KIND_S, 3'd0, 3'd1, 8'h01));
        push_beat(CMD_FIELD, bit_spec(KIND_MOD, 3'd1, 3'd6, 8'h03));
        push_beat(CMD_FIELD, bit_spec(KIND_RM, 3'd1, 3'd0, 8'h07));
        push_beat(CMD_FIELD, bit_spec(KIND_REG, 3'd1, 3'd7, 8'hFF));
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        push_beat(CMD_FIELD, random_spec(KIND_DATALO));
        push_beat(CMD_FIELD, random_spec(KIND_DATAHI));
        push_beat(CMD_FIELD, random_spec(KIND_DATA8));
        push_forced(KIND_OPEXT, 8'hFF, 3'd7);
        push_beat(CMD_FIELD, random_spec(KIND_NONE));
        push_beat(CMD_FIELD, random_spec(KIND_BAD_FIRST));
        push_beat(CMD_FIELD, random_spec(KIND_BAD_LAST));

        // 8 bit displacement with sign extension, IP step halves, overrun
        push_start(48'hFFFF_0080_4100);
        push_beat(CMD_FIELD, bit_spec(KIND_MOD, 3'd1, 3'd6, 8'h03));
        push_beat(CMD_FIELD, bit_spec(KIND_RM, 3'd1, 3'd0, 8'h07));
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        push_beat(CMD_FIELD, random_spec(KIND_INC8));
        push_beat(CMD_FIELD, random_spec(KIND_INCLO));
        push_beat(CMD_FIELD, random_spec(KIND_INCHI));
        push_beat(CMD_FIELD, random_spec(KIND_ADDRLO));
        push_beat(CMD_FIELD, random_spec(KIND_ADDRHI));

        // forced bit fields steer displacement and high data byte
        push_start(48'h0000_00FF_8001);
        push_forced(KIND_V, 8'h00, 3'd0);
        push_forced(KIND_W, 8'hFE, 3'd0);
        push_beat(CMD_FIELD, random_spec(KIND_DATAHI));
        push_forced(KIND_MOD, 8'h03, 3'd0);
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        push_forced(KIND_MOD, 8'h00, 3'd0);
        push_forced(KIND_RM, 8'h05, 3'd0);
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        push_forced(KIND_MOD, 8'h02, 3'd0);
        push_beat(CMD_FIELD, random_spec(KIND_DISP));
        push_beat(CMD_FIELD, bit_spec(KIND_SR, 3'd5, 3'd3, 8'h03));

        while (pending_specs.size() < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 99) < 75)
                push_instruction();
            else if ($urandom_range(0, 3) == 0)
                push_beat(CMD_START, random_spec(KIND_NONE));
            else
            begin
                s = random_spec(5'($urandom_range(0, 31)));
                s.byte_index = 3'($urandom_range(0, 7));
                push_beat(CMD_FIELD, s);
            end
        end
    endtask

    function automatic logic [79:0] pack_spec(input item_t s);
        return {4'h0, s.byte_index, s.field_mask, s.shift_amt, s.force_val,
                s.force_en, s.field_kind, s.instr_bytes};
    endfunction

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_field(pending_specs[0]);
                pending_specs.pop_front();
                items_sent <= items_sent + 1;
                src_gap = pick_gap();
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;   // hold the offered item
            else if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_specs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pack_spec(pending_specs[0].spec);
                s_axis_tuser <= pending_specs[0].cmd;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!pressure_done && items_sent >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.field_code = m_axis_tuser;
            got.field_value = m_axis_tdata[15:0];
            got.bytes_consumed = m_axis_tdata[OUT_CNT_LSB +: 3];
            got.w_was_forced = m_axis_tdata[OUT_WF_BIT];
            got.overrun = m_axis_tdata[OUT_OVR_BIT];
            if (expected_fields.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: code %0d value %h count %0d wf %b ovr %b",
                             got.field_code, got.field_value, got.bytes_consumed,
                             got.w_was_forced, got.overrun);
                mismatch_count++;
            end
            else
            begin
                want = expected_fields.pop_front();
                if (got.field_code !== want.field_code
                    || got.field_value !== want.field_value
                    || got.bytes_consumed !== want.bytes_consumed
                    || got.w_was_forced !== want.w_was_forced
                    || got.overrun !== want.overrun)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"mismatch: expected code %0d value %h count %0d wf %b",
                                  " ovr %b, got code %0d value %h count %0d wf %b ovr %b"},
                                 want.field_code, want.field_value, want.bytes_consumed,
                                 want.w_was_forced, want.overrun,
                                 got.field_code, got.field_value, got.bytes_consumed,
                                 got.w_was_forced, got.overrun);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Cycle counter: calm stretches and run limit
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count % 400) >= 320;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending_specs.size() != 0 || s_axis_tvalid || expected_fields.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
